>>> hdl/box_blur_3x3_rgb_defines.svh
// assertion helpers for the 3x3 box blur
`ifndef BOX_BLUR_3X3_RGB_DEFINES_SVH
`define BOX_BLUR_3X3_RGB_DEFINES_SVH

`ifndef SYNTH
`define BB_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);
`define BB_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) !(expr)) else $error(msg);
`else
`define BB_ASSERT(lbl, prop, msg)
`define BB_NEVER(lbl, expr, msg)
`endif

`endif

>>> hdl/bbrgb_pkg.sv
package bbrgb_pkg;

    localparam int MAX_WIDTH    = 2048;
    localparam int MAX_HEIGHT   = 4096;

    localparam int PIX_W        = 24;
    localparam int LS_W         = 2 * PIX_W;          // above and current row side by side
    localparam int WIDTH_REG_W  = 12;
    localparam int HEIGHT_REG_W = 13;
    localparam int COL_W        = $clog2(MAX_WIDTH);
    localparam int ROW_W        = $clog2(MAX_HEIGHT + 2);   // draining runs past the last row
    localparam int OROW_W       = $clog2(MAX_HEIGHT);
    localparam int CFG_ADDR_W   = 3;

    localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
    localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

    // register index taken from the word address bit
    localparam logic REG_IDX_WIDTH  = 1'b0;
    localparam logic REG_IDX_HEIGHT = 1'b1;

    localparam logic ACT_PIXEL = 1'b0;
    localparam logic ACT_FLUSH = 1'b1;

    // floor(s / 9) = (s * 7282) >> 16, exact for s < 32768
    localparam int SUM_W      = 12;
    localparam int DIV9_W     = 13;
    localparam int PROD_W     = SUM_W + DIV9_W;
    localparam int DIV9_SHIFT = 16;
    localparam logic [DIV9_W-1:0] DIV9_MUL = DIV9_W'(7282);

    typedef logic [PIX_W-1:0] t_pix;
    typedef logic [SUM_W-1:0] t_sum;

endpackage

>>> hdl/bbrgb_ram.sv
module bbrgb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> hdl/box_blur_3x3_rgb.sv
// 3x3 box blur over an rgb pixel stream, one word per clock sustained while the master side takes results.
// a result passes the stage 1, stage 2, stage 3 and output registers after the word that completes it is taken;
// output lags input by one row plus one pixel, and flush words drain the tail.
// throughput is set by the single line store port pair: one read and one write per cycle.
// a height-one frame holds s_axis_tready low at its first drain position, which the block steps on its own.
// reset (i_rst_n low, synchronous) restores 640x480, clears counters, window and pipeline.
`include "box_blur_3x3_rgb_defines.svh"

module box_blur_3x3_rgb
    import bbrgb_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [23:0]           s_axis_tdata,   // red_in, green_in, blue_in
    input  logic [0:0]            s_axis_tuser,   // action
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [23:0]           m_axis_tdata,   // red_out, green_out, blue_out
    output logic                  m_axis_tlast
);

    // configuration and position counters
    logic [WIDTH_REG_W-1:0]  r_width;
    logic [HEIGHT_REG_W-1:0] r_height;
    logic [COL_W-1:0]        r_in_col,  n_in_col;
    logic [ROW_W-1:0]        r_in_row,  n_in_row;
    logic [COL_W-1:0]        r_out_col, n_out_col;
    logic [OROW_W-1:0]       r_out_row, n_out_row;

    // stage 1: line store read data arrives
    logic             r_s1_valid;
    logic             r_s1_res;
    logic             r_s1_last;
    t_pix             r_s1_pix;
    logic [COL_W-1:0] r_s1_addr;
    logic [2:0]       r_s1_rmask;
    logic [2:0]       r_s1_cmask;
    logic             r_byp;
    logic [LS_W-1:0]  r_byp_data;

    t_pix             r_win [9];

    // stage 2: window summed
    logic             r_s2_res;
    logic             r_s2_last;
    logic [2:0]       r_s2_rmask;
    logic [2:0]       r_s2_cmask;

    // stage 3: sums divided
    logic             r_s3_res;
    logic             r_s3_last;
    t_sum             r_s3_sum [3];

    logic             r_out_valid;
    logic [23:0]      r_out_data;
    logic             r_out_last;

    logic                    cfg_wr;
    logic [WIDTH_REG_W-1:0]  cfg_width;
    logic [HEIGHT_REG_W-1:0] cfg_height;
    logic                    en;
    logic                    draining;
    logic                    emit;
    logic                    fill;
    logic                    step;
    t_pix                    step_pix;
    logic [WIDTH_REG_W-1:0]  col_inc;
    logic [WIDTH_REG_W-1:0]  ocol_inc;
    logic [HEIGHT_REG_W-1:0] orow_inc;
    logic                    col_wrap;
    logic                    ocol_end;
    logic                    orow_end;
    logic                    last;
    logic [2:0]              rmask;
    logic [2:0]              cmask;

    logic [LS_W-1:0]         ram_rdata;
    logic [LS_W-1:0]         s1_rd;
    t_pix                    s1_a;
    t_pix                    s1_b;
    logic                    ram_we;
    logic [LS_W-1:0]         ram_wdata;

    t_sum                    s2_sum [3];
    logic [PROD_W-1:0]       s3_prod [3];
    logic [7:0]              s3_q [3];

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        cfg_width = pwdata[WIDTH_REG_W-1:0];
        if (cfg_width == '0) begin
            cfg_width = WIDTH_REG_W'(1);
        end else if (cfg_width > WIDTH_REG_W'(MAX_WIDTH)) begin
            cfg_width = WIDTH_REG_W'(MAX_WIDTH);
        end
        cfg_height = pwdata[HEIGHT_REG_W-1:0];
        if (cfg_height == '0) begin
            cfg_height = HEIGHT_REG_W'(1);
        end else if (cfg_height > HEIGHT_REG_W'(MAX_HEIGHT)) begin
            cfg_height = HEIGHT_REG_W'(MAX_HEIGHT);
        end
    end

    always_comb begin
        case (paddr[2])
            REG_IDX_WIDTH:  prdata = 32'(r_width);
            REG_IDX_HEIGHT: prdata = 32'(r_height);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RESET;
            r_height <= HEIGHT_RESET;
        end else if (cfg_wr) begin
            case (paddr[2])
                REG_IDX_WIDTH:  r_width  <= cfg_width;
                REG_IDX_HEIGHT: r_height <= cfg_height;
                default: ;
            endcase
        end
    end

    // ---------------- stream position control ----------------
    // the pipe moves unless a finished result is stuck at the output while another waits in stage 3
    assign en       = !r_out_valid || m_axis_tready || !r_s3_res;
    assign draining = r_in_row >= ROW_W'(r_height);
    assign emit     = (r_in_row >= ROW_W'(2)) || (r_in_row == ROW_W'(1) && r_in_col != '0);
    // height of one: the first drain position yields nothing, so take it on our own
    assign fill     = draining && !emit;

    assign s_axis_tready = en && !fill;

    always_comb begin
        if (fill) begin
            step = en;
        end else begin
            step = s_axis_tvalid && s_axis_tready &&
                   (draining || s_axis_tuser[0] == ACT_PIXEL);
        end
        step_pix = draining ? '0 : {s_axis_tdata[7:0], s_axis_tdata[15:8], s_axis_tdata[23:16]};
    end

    assign col_inc  = {1'b0, r_in_col} + WIDTH_REG_W'(1);
    assign col_wrap = col_inc >= r_width;
    assign ocol_inc = {1'b0, r_out_col} + WIDTH_REG_W'(1);
    assign ocol_end = ocol_inc >= r_width;
    assign orow_inc = {1'b0, r_out_row} + HEIGHT_REG_W'(1);
    assign orow_end = orow_inc >= r_height;
    assign last     = orow_end && ocol_end;
    assign rmask    = {!orow_end, 1'b1, r_out_row != '0};
    assign cmask    = {!ocol_end, 1'b1, r_out_col != '0};

    always_comb begin
        n_in_col  = r_in_col;
        n_in_row  = r_in_row;
        n_out_col = r_out_col;
        n_out_row = r_out_row;
        if (cfg_wr) begin
            n_in_col  = '0;
            n_in_row  = '0;
            n_out_col = '0;
            n_out_row = '0;
        end else if (step) begin
            if (col_wrap) begin
                n_in_col = '0;
                n_in_row = r_in_row + ROW_W'(1);
            end else begin
                n_in_col = col_inc[COL_W-1:0];
            end
            if (emit) begin
                if (last) begin
                    n_in_col  = '0;
                    n_in_row  = '0;
                    n_out_col = '0;
                    n_out_row = '0;
                end else if (ocol_end) begin
                    n_out_col = '0;
                    n_out_row = orow_inc[OROW_W-1:0];
                end else begin
                    n_out_col = ocol_inc[COL_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_col  <= '0;
            r_in_row  <= '0;
            r_out_col <= '0;
            r_out_row <= '0;
        end else begin
            r_in_col  <= n_in_col;
            r_in_row  <= n_in_row;
            r_out_col <= n_out_col;
            r_out_row <= n_out_row;
        end
    end

    // ---------------- line stores ----------------
    // forward the write of the previous position when it hit the same column
    assign s1_rd     = r_byp ? r_byp_data : ram_rdata;
    assign s1_a      = s1_rd[LS_W-1:PIX_W];
    assign s1_b      = s1_rd[PIX_W-1:0];
    assign ram_we    = en && r_s1_valid;
    assign ram_wdata = {s1_b, r_s1_pix};

    bbrgb_ram #(
        .WIDTH (LS_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_s1_addr),
        .i_wdata (ram_wdata),
        .i_re    (step),
        .i_raddr (r_in_col),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
            r_s1_res   <= 1'b0;
            r_byp      <= 1'b0;
        end else begin
            if (en) begin
                r_s1_valid <= step;
                r_s1_res   <= step && emit;
            end
            if (step) begin
                r_byp <= ram_we && (r_s1_addr == r_in_col);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s1_pix   <= step_pix;
            r_s1_addr  <= r_in_col;
            r_s1_rmask <= rmask;
            r_s1_cmask <= cmask;
            r_s1_last  <= last;
        end
        if (step) begin
            r_byp_data <= ram_wdata;
        end
    end

    // ---------------- window ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 9; i++) begin
                r_win[i] <= '0;
            end
        end else if (en && r_s1_valid) begin
            for (int r = 0; r < 3; r++) begin
                r_win[r*3]     <= r_win[r*3 + 1];
                r_win[r*3 + 1] <= r_win[r*3 + 2];
            end
            r_win[2] <= s1_a;
            r_win[5] <= s1_b;
            r_win[8] <= r_s1_pix;
        end
    end

    // ---------------- sum and divide ----------------
    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s2_sum[ch] = '0;
            for (int r = 0; r < 3; r++) begin
                for (int k = 0; k < 3; k++) begin
                    if (r_s2_rmask[r] && r_s2_cmask[k]) begin
                        s2_sum[ch] = s2_sum[ch] + SUM_W'(r_win[r*3 + k][ch*8 +: 8]);
                    end
                end
            end
        end
    end

    always_comb begin
        for (int ch = 0; ch < 3; ch++) begin
            s3_prod[ch] = PROD_W'(r_s3_sum[ch]) * PROD_W'(DIV9_MUL);
            s3_q[ch]    = s3_prod[ch][DIV9_SHIFT +: 8];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_res    <= 1'b0;
            r_s3_res    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (en) begin
                r_s2_res <= r_s1_valid && r_s1_res;
                r_s3_res <= r_s2_res;
            end
            if (!r_out_valid || m_axis_tready) begin
                r_out_valid <= r_s3_res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s2_rmask <= r_s1_rmask;
            r_s2_cmask <= r_s1_cmask;
            r_s2_last  <= r_s1_last;
            r_s3_sum   <= s2_sum;
            r_s3_last  <= r_s2_last;
        end
        if (!r_out_valid || m_axis_tready) begin
            // lane 0 is red, lane 2 is blue
            r_out_data <= {s3_q[0], s3_q[1], s3_q[2]};
            r_out_last <= r_s3_last;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

    // ---------------- checks ----------------
    `BB_ASSERT(a_last_clears_pos, r_s1_valid && r_s1_res && r_s1_last |-> r_in_row == '0 && r_in_col == '0 && r_out_row == '0, "frame end did not clear the position counters")
    `BB_NEVER(a_in_row_bound, {1'b0, r_in_row} > {1'b0, r_height} + 14'd1, "input row ran past the drain limit")
    `BB_NEVER(a_out_pos_bound, {1'b0, r_out_row} >= r_height || {1'b0, r_out_col} >= r_width, "output position left the frame")

endmodule
